>>> rtl/core/csp_pkg.sv
// shared types and constants for the counting semaphore pool
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package csp_pkg;

  // pool dimensions
  localparam int NUM_SEMS    = 16;   // 2 .. 16
  localparam int NUM_PROCS   = 16;   // 2 .. 16
  localparam int COUNT_WIDTH = 16;   // 4 .. 32

  localparam int SEM_W  = $clog2(NUM_SEMS);
  localparam int PROC_W = $clog2(NUM_PROCS);

  // fixed field widths of the ports
  localparam int OPCODE_W = 2;
  localparam int ID_W     = 4;
  localparam int INIT_W   = 16;
  localparam int STATUS_W = 3;

  // command queue between front and back, depth is a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_CREATE = 2'd0,
    OP_P      = 2'd1,
    OP_V      = 2'd2,
    OP_FREE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_BLOCKED = 3'd1,
    ST_ILLEGAL = 3'd2,
    ST_FULL    = 3'd3,
    ST_WAITERS = 3'd4
  } status_t;

  typedef logic signed [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [SEM_W-1:0]              sem_idx_t;
  typedef logic [PROC_W-1:0]             proc_idx_t;

  localparam cnt_t CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam cnt_t CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

  // classified request handed from front to back
  typedef struct packed {
    op_t       op;
    sem_idx_t  sid;
    proc_idx_t pid;
    logic      bad_id;   // slot beyond the pool, or process beyond it on a P
    cnt_t      init;     // already clamped to the count range
  } csp_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/csp_req_if.sv
// request channel: valid/ready plus one request beat
// depends on csp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface csp_req_if
  import csp_pkg::*;
  ;
  logic                     valid;
  logic                     ready;
  logic [OPCODE_W-1:0]      opcode;
  logic [ID_W-1:0]          sem_id;
  logic signed [INIT_W-1:0] init_value;
  logic [ID_W-1:0]          proc_id;

  modport source (output valid, opcode, sem_id, init_value, proc_id, input ready);
  modport sink   (input valid, opcode, sem_id, init_value, proc_id, output ready);
endinterface

`default_nettype wire

>>> rtl/core/csp_rsp_if.sv
// response channel: valid/ready plus one result beat
// depends on csp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface csp_rsp_if
  import csp_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     new_sem_id;
  logic                woken_valid;
  logic [ID_W-1:0]     woken_proc;

  modport source (output valid, status, new_sem_id, woken_valid, woken_proc, input ready);
  modport sink   (input valid, status, new_sem_id, woken_valid, woken_proc, output ready);
endinterface

`default_nettype wire

>>> rtl/core/csp_front.sv
// front end: takes request beats, classifies them and queues them for the back end
// depends on csp_pkg and csp_req_if
`timescale 1ns / 1ps
`default_nettype none

module csp_front
  import csp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  csp_req_if.sink    req,
  output csp_cmd_t   cmd,
  output logic       cmd_valid,
  input  wire logic  cmd_pop
);

  csp_cmd_t               queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0]      wr_ptr;
  logic [QPTR_W-1:0]      rd_ptr;
  logic [QCNT_W-1:0]      fill;
  csp_cmd_t               cls;
  logic signed [32:0]     init_x;
  logic signed [32:0]     init_sat;
  logic                   push;

  // classify: decode, range checks, clamp of the initial count
  always_comb begin
    init_x = 33'(req.init_value);
    if (init_x > 33'(CNT_MAX)) begin
      init_sat = 33'(CNT_MAX);
    end else if (init_x < 33'(CNT_MIN)) begin
      init_sat = 33'(CNT_MIN);
    end else begin
      init_sat = init_x;
    end
    cls.op     = op_t'(req.opcode);
    cls.sid    = SEM_W'(req.sem_id);
    cls.pid    = PROC_W'(req.proc_id);
    cls.init   = COUNT_WIDTH'(init_sat);
    cls.bad_id = (cls.op != OP_CREATE) &&
                 ((32'(req.sem_id) >= NUM_SEMS) ||
                  ((cls.op == OP_P) && (32'(req.proc_id) >= NUM_PROCS)));
  end

  assign req.ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign push      = req.valid && req.ready;
  assign cmd_valid = (fill != '0);
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, cmd_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/csp_back.sv
// back end: semaphore state, wait-queue links and the registered result beat
// depends on csp_pkg and csp_rsp_if
`timescale 1ns / 1ps
`default_nettype none

module csp_back
  import csp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire csp_cmd_t  cmd,
  input  wire logic      cmd_valid,
  output logic           cmd_pop,
  csp_rsp_if.source      rsp
);

  // per-slot state
  logic [NUM_SEMS-1:0] slot_in_use;
  logic [NUM_SEMS-1:0] queue_nonempty;
  cnt_t                count      [NUM_SEMS];
  proc_idx_t           queue_head [NUM_SEMS];
  proc_idx_t           queue_tail [NUM_SEMS];
  // per-process link to the next waiter
  proc_idx_t           next_waiter [NUM_PROCS];

  // result register
  logic                out_valid;
  status_t             out_status;
  logic [ID_W-1:0]     out_new_id;
  logic                out_wv;
  logic [ID_W-1:0]     out_wp;

  logic                exec;
  logic                free_found;
  sem_idx_t            free_idx;
  sem_idx_t            wr_slot;
  logic                in_use_s;
  logic                nonempty_s;
  cnt_t                cnt_s;
  cnt_t                cnt_dec;
  cnt_t                cnt_inc;
  proc_idx_t           head_s;
  proc_idx_t           tail_s;
  proc_idx_t           link_h;

  logic [NUM_SEMS-1:0] in_use_next;
  logic [NUM_SEMS-1:0] nonempty_next;
  logic                cnt_wr;
  cnt_t                cnt_wdata;
  logic                head_wr;
  proc_idx_t           head_wdata;
  logic                tail_wr;
  logic                link_wr;
  logic                clr_wr;
  proc_idx_t           clr_addr;

  status_t             st;
  logic [ID_W-1:0]     nid;
  logic                wv;
  logic [ID_W-1:0]     wp;

  assign exec    = cmd_valid && (!out_valid || rsp.ready);
  assign cmd_pop = exec;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SEMS - 1; i >= 0; i--) begin
      if (!slot_in_use[i]) begin
        free_found = 1'b1;
        free_idx   = SEM_W'(i);
      end
    end
  end

  assign in_use_s   = slot_in_use[cmd.sid];
  assign nonempty_s = queue_nonempty[cmd.sid];
  assign cnt_s      = count[cmd.sid];
  assign head_s     = queue_head[cmd.sid];
  assign tail_s     = queue_tail[cmd.sid];
  assign link_h     = next_waiter[head_s];
  assign cnt_dec    = (cnt_s == CNT_MIN) ? cnt_s : cnt_s - 1'b1;
  assign cnt_inc    = (cnt_s == CNT_MAX) ? cnt_s : cnt_s + 1'b1;

  always_comb begin
    st            = ST_OK;
    nid           = '0;
    wv            = 1'b0;
    wp            = '0;
    in_use_next   = slot_in_use;
    nonempty_next = queue_nonempty;
    wr_slot       = cmd.sid;
    cnt_wr        = 1'b0;
    cnt_wdata     = cmd.init;
    head_wr       = 1'b0;
    head_wdata    = cmd.pid;
    tail_wr       = 1'b0;
    link_wr       = 1'b0;
    clr_wr        = 1'b0;
    clr_addr      = cmd.pid;
    if (cmd.op == OP_CREATE) begin
      if (!free_found) begin
        st = ST_FULL;
      end else begin
        wr_slot                = free_idx;
        cnt_wr                 = 1'b1;
        in_use_next[free_idx]  = 1'b1;
        nonempty_next[free_idx] = 1'b0;
        nid                    = ID_W'(free_idx);
      end
    end else if (cmd.bad_id || !in_use_s) begin
      st = ST_ILLEGAL;
    end else begin
      case (cmd.op)
        OP_P: begin
          cnt_wr    = 1'b1;
          cnt_wdata = cnt_dec;
          if (cnt_dec[COUNT_WIDTH-1]) begin
            // caller joins the tail of the wait queue
            link_wr                = nonempty_s;
            head_wr                = !nonempty_s;
            tail_wr                = 1'b1;
            clr_wr                 = 1'b1;
            nonempty_next[cmd.sid] = 1'b1;
            st                     = ST_BLOCKED;
          end
        end
        OP_V: begin
          cnt_wr    = 1'b1;
          cnt_wdata = cnt_inc;
          if (nonempty_s) begin
            // oldest waiter leaves from the head
            wv       = 1'b1;
            wp       = ID_W'(head_s);
            clr_wr   = 1'b1;
            clr_addr = head_s;
            if (head_s == tail_s) begin
              nonempty_next[cmd.sid] = 1'b0;
            end else begin
              head_wr    = 1'b1;
              head_wdata = link_h;
            end
          end
        end
        OP_FREE: begin
          if (nonempty_s) begin
            st = ST_WAITERS;
          end else begin
            in_use_next[cmd.sid] = 1'b0;
          end
        end
        default: st = ST_ILLEGAL;
      endcase
    end
  end

  // payload stores, no reset needed
  always_ff @(posedge clk) begin
    if (exec) begin
      if (cnt_wr) begin
        count[wr_slot] <= cnt_wdata;
      end
      if (head_wr) begin
        queue_head[cmd.sid] <= head_wdata;
      end
      if (tail_wr) begin
        queue_tail[cmd.sid] <= cmd.pid;
      end
      if (link_wr) begin
        next_waiter[tail_s] <= cmd.pid;
      end
      // clearing the link wins when both hit the same process
      if (clr_wr) begin
        next_waiter[clr_addr] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_in_use    <= '0;
      queue_nonempty <= '0;
      out_valid      <= 1'b0;
      out_status     <= ST_OK;
      out_new_id     <= '0;
      out_wv         <= 1'b0;
      out_wp         <= '0;
    end else begin
      if (exec) begin
        slot_in_use    <= in_use_next;
        queue_nonempty <= nonempty_next;
        out_valid      <= 1'b1;
        out_status     <= st;
        out_new_id     <= nid;
        out_wv         <= wv;
        out_wp         <= wp;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.new_sem_id  = out_new_id;
  assign rsp.woken_valid = out_wv;
  assign rsp.woken_proc  = out_wp;

endmodule

`default_nettype wire

>>> rtl/core/counting_semaphore_pool.sv
// top level of the counting semaphore pool: front end, command queue, back end
// depends on csp_pkg, csp_req_if, csp_rsp_if, csp_front and csp_back
//
//   channel | direction | beat
//   --------+-----------+-------------------------------------------------
//   req     | in        | opcode, sem_id, init_value, proc_id
//   rsp     | out       | status, new_sem_id, woken_valid, woken_proc
//
// sustained rate is one request per cycle while rsp stays ready; each request gives one response
// a request is first written into the command queue, then the back end registers its response
// the back end works out a whole operation combinationally on small register files;
// the lowest-free-slot search and the head-to-next-waiter link lookup set its path
// rst is synchronous: the pool comes up empty with no waiters and no response pending
// a stalled rsp holds its beat; the back end then stops and the two-deep queue
// absorbs requests until it fills, then req.ready drops

`timescale 1ns / 1ps
`default_nettype none

module counting_semaphore_pool
  import csp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  csp_req_if.sink    req,
  csp_rsp_if.source  rsp
);

  // classified requests travel through the queue inside the front end
  csp_cmd_t cmd;
  logic     cmd_valid;
  logic     cmd_pop;

  csp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  // state update and the registered response beat
  csp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

>>> rtl/core/csp_checker.sv
// port-level checks on the response channel of counting_semaphore_pool
// depends on csp_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module csp_checker
  import csp_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                rsp_valid,
  input wire logic                rsp_ready,
  input wire logic [STATUS_W-1:0] status,
  input wire logic [ID_W-1:0]     new_sem_id,
  input wire logic                woken_valid,
  input wire logic [ID_W-1:0]     woken_proc
);

  // a stalled beat stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(new_sem_id)
      && $stable(woken_valid) && $stable(woken_proc))
    else $error("rsp beat changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp valid right after reset");

  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status <= ST_WAITERS)
    else $error("status code out of range");

  // only a good V wakes anyone
  a_woken: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && woken_valid |-> status == ST_OK && new_sem_id == '0)
    else $error("wake reported with a failing status");

  a_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !woken_valid |-> woken_proc == '0)
    else $error("woken_proc set with no wake");

endmodule

bind counting_semaphore_pool csp_checker u_csp_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .new_sem_id  (rsp.new_sem_id),
  .woken_valid (rsp.woken_valid),
  .woken_proc  (rsp.woken_proc)
);

`default_nettype wire
